@@ rtl/robin_hood_hash_table_unit_defines.svh @@
// Assertion macros for the Robin Hood hash table unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_UNIT_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RHHT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rhht assertion failed");
`define RHHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rhht check failed");
`else
`define RHHT_ASSERT(lbl, clk, rstn, prop)
`define RHHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/rhht_pkg.sv @@
// Shared types and codes for the Robin Hood hash table unit.
// No dependencies.
package rhht_pkg;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_ABSENT   = 2'd0,
    STS_FOUND    = 2'd1,
    STS_INSERTED = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CHK,
    ST_UPD,
    ST_INS_RD,
    ST_INS_CHK,
    ST_RM_RD,
    ST_RM_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] khash;
    logic [63:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [8:0]  occupancy;
  } rsp_t;

  localparam logic [8:0] MAX_ENTRIES_RST = 9'd192;

endpackage

@@ rtl/rhht_slot_mem.sv @@
// Single-port slot store: one read or one write per cycle, registered read.
// No package dependencies.
module rhht_slot_mem #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 137
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/robin_hood_hash_table_unit.sv @@
// Robin Hood hash table unit: probe walk, insert with swaps, backward-shift remove.
// A get walks the probe chain from the home slot; a set hit then rewrites the value,
// an insert walks on from the miss slot with swaps, and a remove shifts entries back.
// Input stalls from accept until the response word is issued, so one word at a time.
// Reset: a clearing pass over all SLOTS slots empties the store; input stalls meanwhile.
// Depends on rhht_pkg, rhht_slot_mem and robin_hood_hash_table_unit_defines.svh.
`include "robin_hood_hash_table_unit_defines.svh"
module robin_hood_hash_table_unit
  import rhht_pkg::*;
#(
  parameter int SLOTS = 256  // power of two, 8..65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // one slot word: used flag, home index, key, value
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] home;
    logic [63:0]      key;
    logic [63:0]      value;
  } slot_t;

  localparam int SW = $bits(slot_t);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W:0]    d_q, d_d;       // probe distance, or shift count on remove
  slot_t             car_q, car_d;   // carried entry (request, then displaced)
  slot_t             hold_q, hold_d; // word at the hit slot
  logic [1:0]        act_q, act_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        sts_q, sts_d;
  logic [63:0]       fnd_q, fnd_d;
  logic [8:0]        max_q;
  rsp_t              out_q, out_d;
  logic              ov_q, ov_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  slot_t             mem_wdata;
  logic [SW-1:0]     mem_rdata;
  slot_t             rd;

  logic [IDX_W-1:0]  hdist;
  logic              full;
  logic              take;

  rhht_slot_mem #(.DEPTH(SLOTS), .DATA_W(SW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign rd    = slot_t'(mem_rdata);
  // in the checking states the read word belongs to idx_q (idx_q+1 on remove)
  assign hdist = (state_q == ST_RM_CHK) ? (idx_q + IDX_W'(1) - rd.home) : (idx_q - rd.home);
  assign full  = (32'(cnt_q) >= 32'(max_q)) || (32'(cnt_q) >= 32'(SLOTS));
  assign take  = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (idx_q == '1) state_d = ST_IDLE;
      ST_IDLE:   if (take) state_d = ST_LK_RD;
      ST_LK_RD:  state_d = ST_LK_CHK;
      ST_LK_CHK: begin
        if (!rd.used || d_q > {1'b0, hdist} ||
            (rd.key != car_q.key && d_q == (IDX_W+1)'(SLOTS - 1))) begin
          if (act_q == ACT_SET && !full) state_d = ST_INS_RD;
          else                           state_d = ST_DONE;
        end else if (rd.key == car_q.key) begin
          case (act_q)
            ACT_SET:    state_d = ST_UPD;
            ACT_REMOVE: state_d = ST_RM_RD;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_UPD:     state_d = ST_DONE;
      ST_INS_RD:  state_d = ST_INS_CHK;
      ST_INS_CHK: begin
        if (!rd.used)                 state_d = ST_DONE;
        else if (d_q > {1'b0, hdist}) state_d = ST_INS_RD;
      end
      ST_RM_RD:  state_d = ST_RM_CHK;
      ST_RM_CHK: begin
        if (!rd.used || hdist == '0 || d_q == (IDX_W+1)'(SLOTS - 1)) state_d = ST_DONE;
        else                                                          state_d = ST_RM_RD;
      end
      ST_DONE:   if (!ov_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    idx_d     = idx_q;
    d_d       = d_q;
    car_d     = car_q;
    hold_d    = hold_q;
    act_d     = act_q;
    cnt_d     = cnt_q;
    sts_d     = sts_q;
    fnd_d     = fnd_q;
    out_d     = out_q;
    ov_d      = ov_q;
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = car_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        idx_d     = idx_q + IDX_W'(1);
      end
      ST_IDLE: begin
        if (take) begin
          car_d = '{used: 1'b1, home: in_req_i.khash[IDX_W-1:0],
                    key: in_req_i.key, value: in_req_i.new_value};
          act_d = in_req_i.action;
          idx_d = in_req_i.khash[IDX_W-1:0];
          d_d   = '0;
          sts_d = STS_ABSENT;
          fnd_d = '0;
        end
      end
      ST_LK_CHK: begin
        if (!rd.used || d_q > {1'b0, hdist} ||
            (rd.key != car_q.key && d_q == (IDX_W+1)'(SLOTS - 1))) begin
          // miss: insert resumes at this very slot and distance
          if (act_q == ACT_SET && full) sts_d = STS_FULL;
        end else if (rd.key == car_q.key) begin
          hold_d = rd;
          sts_d  = STS_FOUND;
          if (act_q == ACT_REMOVE) begin
            cnt_d = cnt_q - CNT_W'(1);
            d_d   = '0;
          end else if (act_q != ACT_SET) begin
            fnd_d = rd.value;
          end
        end else begin
          idx_d    = idx_q + IDX_W'(1);
          d_d      = d_q + (IDX_W+1)'(1);
          mem_addr = idx_q + IDX_W'(1);
        end
      end
      ST_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = '{used: 1'b1, home: hold_q.home, key: hold_q.key, value: car_q.value};
      end
      ST_INS_CHK: begin
        if (!rd.used) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          sts_d  = STS_INSERTED;
        end else if (d_q > {1'b0, hdist}) begin
          // resident is closer to home: swap and carry it on
          mem_we = 1'b1;
          car_d  = rd;
          d_d    = {1'b0, hdist} + (IDX_W+1)'(1);
          idx_d  = idx_q + IDX_W'(1);
        end else begin
          idx_d    = idx_q + IDX_W'(1);
          d_d      = d_q + (IDX_W+1)'(1);
          mem_addr = idx_q + IDX_W'(1);
        end
      end
      ST_RM_RD: mem_addr = idx_q + IDX_W'(1);
      ST_RM_CHK: begin
        mem_we = 1'b1;
        if (!rd.used || hdist == '0 || d_q == (IDX_W+1)'(SLOTS - 1)) begin
          mem_wdata = '0;
        end else begin
          mem_wdata = rd;
          idx_d     = idx_q + IDX_W'(1);
          d_d       = d_q + (IDX_W+1)'(1);
        end
      end
      ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          out_d = '{status: sts_q, found_value: fnd_q, occupancy: 9'(cnt_q)};
          ov_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      max_q   <= MAX_ENTRIES_RST;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && cfg_ready_o) max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    car_q  <= car_d;
    hold_q <= hold_d;
    act_q  <= act_d;
    sts_q  <= sts_d;
    fnd_q  <= fnd_d;
    out_q  <= out_d;
  end

  // checks
  `RHHT_ASSERT(a_cnt_bound, clk_i, rst_ni, 32'(cnt_q) <= 32'(SLOTS))
  `RHHT_ASSERT(a_rsp_from_done, clk_i, rst_ni, $rose(ov_q) |-> $past(state_q == ST_DONE))
  `RHHT_ASSERT(a_no_write_idle, clk_i, rst_ni, (state_q == ST_IDLE) |-> !mem_we)
endmodule

@@ dv/rhht_checker.sv @@
// Scoreboard for the Robin Hood hash table unit: watches the request, response and
// config channels, predicts each response and compares. Depends on rhht_pkg.
`timescale 1ns / 100ps
module rhht_checker
  import rhht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [8:0]  cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  localparam int NSLOT = 256;

  logic [63:0] tbl_key  [NSLOT];
  logic [63:0] tbl_val  [NSLOT];
  logic [7:0]  tbl_home [NSLOT];
  logic        tbl_used [NSLOT];
  logic [8:0]  n_entries;
  logic [8:0]  entry_limit;
  rsp_t        rsp_queue[$];

  assign pending_o = rsp_queue.size();

  function automatic logic [7:0] dist_of(logic [7:0] idx);
    return idx - tbl_home[idx];
  endfunction

  function automatic bit find_key(logic [63:0] k, logic [7:0] home, output logic [7:0] at);
    logic [7:0] idx;
    at = '0;
    for (int d = 0; d < NSLOT; d++) begin
      idx = home + d[7:0];
      if (!tbl_used[idx]) return 0;
      if (d > int'(dist_of(idx))) return 0;
      if (tbl_key[idx] == k) begin
        at = idx;
        return 1;
      end
    end
    return 0;
  endfunction

  task automatic insert_entry(logic [63:0] k, logic [63:0] v, logic [7:0] home);
    int d;
    logic [7:0] idx;
    logic [63:0] tk, tv;
    logic [7:0] th;
    d = 0;
    for (int s = 0; s < NSLOT; s++) begin
      idx = home + d[7:0];
      if (!tbl_used[idx]) begin
        tbl_used[idx] = 1'b1;
        tbl_key[idx]  = k;
        tbl_val[idx]  = v;
        tbl_home[idx] = home;
        n_entries++;
        return;
      end
      if (d > int'(dist_of(idx))) begin
        // carried entry is poorer: take the slot, carry the resident on
        tk = tbl_key[idx]; tv = tbl_val[idx]; th = tbl_home[idx];
        tbl_key[idx] = k; tbl_val[idx] = v; tbl_home[idx] = home;
        k = tk; v = tv; home = th;
        d = int'(logic'(0)) + int'(8'(idx - home));
      end
      d++;
    end
  endtask

  task automatic shift_remove(logic [7:0] idx);
    logic [7:0] nxt;
    n_entries--;
    for (int s = 0; s + 1 < NSLOT; s++) begin
      nxt = idx + 8'd1;
      if (!tbl_used[nxt]) break;
      if (dist_of(nxt) == 0) break;
      tbl_key[idx]  = tbl_key[nxt];
      tbl_val[idx]  = tbl_val[nxt];
      tbl_home[idx] = tbl_home[nxt];
      idx = nxt;
    end
    tbl_used[idx] = 1'b0;
  endtask

  task automatic predict_rsp(req_t r, output rsp_t e);
    logic [7:0] at;
    logic [8:0] lim;
    bit hit;
    hit = find_key(r.key, r.khash[7:0], at);
    e = '0;
    lim = (entry_limit > NSLOT) ? 9'(NSLOT) : entry_limit;
    case (action_e'(r.action))
      ACT_SET: begin
        if (hit) begin
          tbl_val[at] = r.new_value;
          e.status = STS_FOUND;
        end else if (n_entries >= lim) begin
          e.status = STS_FULL;
        end else begin
          insert_entry(r.key, r.new_value, r.khash[7:0]);
          e.status = STS_INSERTED;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          shift_remove(at);
          e.status = STS_FOUND;
        end else begin
          e.status = STS_ABSENT;
        end
      end
      default: begin  // get, and the reserved code behaves as a get
        e.status = hit ? STS_FOUND : STS_ABSENT;
        e.found_value = hit ? tbl_val[at] : '0;
      end
    endcase
    e.occupancy = n_entries;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
      n_entries   = '0;
      entry_limit = MAX_ENTRIES_RST;
      rsp_queue.delete();
      errors_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        a = out_rsp_i;
        if (rsp_queue.size() == 0) begin
          $error("unexpected response word: %p", a);
          errors_o++;
        end else begin
          e = rsp_queue.pop_front();
          if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors_o++;
          end
          if (a.found_value !== e.found_value) begin
            $error("found_value: expected %h, got %h", e.found_value, a.found_value);
            errors_o++;
          end
          if (a.occupancy !== e.occupancy) begin
            $error("occupancy: expected %0d, got %0d", e.occupancy, a.occupancy);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) entry_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        predict_rsp(in_req_i, e);
        rsp_queue.push_back(e);
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the hash table unit testbench: clock, reset, stimulus and verdict.
// Depends on rhht_pkg, robin_hood_hash_table_unit and rhht_checker.
`timescale 1ns / 100ps
module tb_top;
  import rhht_pkg::*;

  localparam int POOL = 320;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;
  int          pending, errors;
  int          cycle_cnt = 0;
  int          word_cnt = 0;

  // key pool with clustered home slots so that probe chains get long
  logic [63:0] pool_key  [POOL];
  logic [63:0] pool_hash [POOL];

  always #5 clk_i = ~clk_i;

  robin_hood_hash_table_unit i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  rhht_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_rsp_i(out_rsp_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stalls, one long hold-off that backs the unit up,
  // and a clean stretch with no stalls.
  always @(negedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= 3000 && cycle_cnt < 3400) out_stall_i <= 1'b1;
    else if (cycle_cnt >= 8000 && cycle_cnt < 14000) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 21);
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  // one word on the request channel; valid stays up while stalled
  task automatic send_word(action_e act, logic [63:0] k, logic [63:0] h, logic [63:0] v);
    // no gaps for a while mid-run
    if (word_cnt < 600 || word_cnt > 800)
      while ($urandom_range(0, 99) < 21) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    in_valid_i = 1'b1;
    in_req_i = '{action: act, key: k, khash: h, new_value: v};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    word_cnt++;
    @(negedge clk_i);
  endtask

  // wait for quiet, then write the occupancy limit
  task automatic write_limit(logic [8:0] lim);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (1200) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = lim;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic refill_pool();
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]  = {$urandom, $urandom};
      pool_hash[i] = {$urandom, $urandom};
      pool_hash[i][7:0] = base + 8'($urandom_range(0, 40));
    end
    pool_key[0] = '0;
    pool_key[1] = '1;
  endtask

  task automatic random_words(int n, int set_pct);
    int p, r;
    action_e act;
    logic [63:0] h;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, POOL - 1);
      r = $urandom_range(0, 99);
      if (r < set_pct) act = ACT_SET;
      else if (r < set_pct + (100 - set_pct) * 3 / 10) act = ACT_REMOVE;
      else if (r < 96) act = ACT_GET;
      else act = ACT_RSVD;
      // mostly the pool's hash; sometimes a stray one
      h = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pool_hash[p];
      send_word(act, pool_key[p], h, {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, a chain wrapping past the last slot,
    // updates, shift-back removes, absent remove, reserved action
    send_word(ACT_GET,    64'h0, 64'h0, 64'h0);
    send_word(ACT_SET,    64'h0, 64'h0, '1);
    send_word(ACT_SET,    '1, '1, 64'h0);
    send_word(ACT_SET,    64'h11, 64'hff, 64'h1);
    send_word(ACT_SET,    64'h12, 64'hfe, 64'h2);
    send_word(ACT_SET,    64'h13, 64'hff, 64'h3);
    send_word(ACT_SET,    64'h14, 64'h00, 64'h4);
    send_word(ACT_GET,    64'h13, 64'hff, 64'h0);
    send_word(ACT_SET,    64'h13, 64'hff, 64'hdead_beef);
    send_word(ACT_GET,    64'h13, 64'hff, '1);
    send_word(ACT_REMOVE, '1, '1, 64'h0);
    send_word(ACT_GET,    64'h13, 64'hff, 64'h0);
    send_word(ACT_GET,    64'h14, 64'h00, 64'h0);
    send_word(ACT_REMOVE, 64'h99, 64'hff, 64'h0);
    send_word(ACT_RSVD,   64'h0, 64'h0, 64'h0);
    send_word(ACT_RSVD,   64'h77, 64'h5, 64'h0);
    send_word(ACT_REMOVE, 64'h12, 64'hfe, 64'h0);
    send_word(ACT_GET,    64'h11, 64'hff, 64'h0);
    send_word(ACT_REMOVE, 64'h0, 64'h0, 64'h0);
    send_word(ACT_GET,    64'h14, 64'h00, 64'h0);

    refill_pool();
    random_words(200, 45);
    write_limit(9'd0);   refill_pool(); random_words(100, 50);
    write_limit(9'd1);   refill_pool(); random_words(150, 40);
    write_limit(9'd256); refill_pool(); random_words(450, 75);
    write_limit(9'd511); random_words(250, 40);
    write_limit(9'd8);   refill_pool(); random_words(250, 45);
    write_limit(9'd100); refill_pool(); random_words(350, 45);

    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ robin_hood_hash_table_unit.f @@
+incdir+rtl
rtl/rhht_pkg.sv
rtl/rhht_slot_mem.sv
rtl/robin_hood_hash_table_unit.sv
dv/rhht_checker.sv
dv/tb_top.sv
